// ===== src/mrrc_pkg.sv =====
// Package for the read-response checker: transaction structs, request and
// status codes, and the byte-wide CRC-16 update. No dependencies.
package mrrc_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 96;

  localparam logic [7:0]  ADDR_RESET    = 8'h01;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  FUNC_EXC_BIT  = 8'h80;
  localparam logic [7:0]  FUNC_READ_HLD = 8'h03;
  localparam logic [7:0]  FUNC_READ_INP = 8'h04;
  localparam int unsigned HDR_BYTES     = 3;
  localparam int unsigned OVERHEAD      = 5;

  localparam logic [1:0] REQ_ARM     = 2'd0;
  localparam logic [1:0] REQ_BYTE    = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd2;
  localparam logic [2:0] ST_BAD_FUNC  = 3'd3;
  localparam logic [2:0] ST_EXCEPTION = 3'd4;
  localparam logic [2:0] ST_BAD_LEN   = 3'd5;
  localparam logic [2:0] ST_BAD_CRC   = 3'd6;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [6:0] byte_index;
    logic [2:0] status;
    logic [7:0] exception_code;
    logic [6:0] payload_length;
  } out_item_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/modbus_read_response_checker_core.sv =====
// Modbus RTU read-registers response checker, top level.
// Depends on mrrc_pkg for transaction structs, codes and the CRC-16 update.
//
// Usage: send an arm transaction, then one transaction per received frame byte,
// or a timeout transaction. The block takes one transaction per clock cycle;
// each result appears in the cycle after its input is accepted, in an output
// register that is refilled in the same cycle it drains, so in_ready falls only
// while a result is held by out_ready low. CRC-16 (init FFFF, poly A001) runs a
// full byte per cycle. Payload bytes are streamed as they arrive and are only
// trusted once the end transaction reports status ok. slave_address may be
// written on the cfg channel, which is always ready, while no frame is active.
module modbus_read_response_checker_core #(
  parameter int unsigned MAX_FRAME_BYTES = mrrc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mrrc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  localparam int unsigned CNT_W   = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned MAX_CNT = MAX_FRAME_BYTES - mrrc_pkg::OVERHEAD;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ADDR, PH_B1_OK, PH_B1_BAD, PH_B2_OK, PH_B2_BAD,
    PH_EXC_LO, PH_EXC_HI, PH_DATA, PH_CRC_LO, PH_CRC_HI
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [CNT_W-1:0]    seen_r, seen_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [7:0]          func_r, func_nxt;
  logic [7:0]          exc_r, exc_nxt;
  logic [7:0]          crc_lo_r, crc_lo_nxt;
  logic [7:0]          addr_r;
  logic                out_valid_r, out_valid_nxt;
  mrrc_pkg::out_item_t out_data_r, out_data_nxt;

  logic                accept;
  logic                res_valid;
  mrrc_pkg::out_item_t res;
  logic [15:0]         crc_byte;
  logic [15:0]         rx_crc;
  logic [CNT_W:0]      data_end;
  logic [7:0]          b;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b        = in_data.rx_byte;
  assign crc_byte = mrrc_pkg::crc16_byte(crc_r, b);
  assign rx_crc   = {b, crc_lo_r};
  assign data_end = {1'b0, count_r} + (CNT_W+1)'(mrrc_pkg::HDR_BYTES);

  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    seen_nxt   = seen_r;
    count_nxt  = count_r;
    func_nxt   = func_r;
    exc_nxt    = exc_r;
    crc_lo_nxt = crc_lo_r;
    res_valid  = 1'b0;
    res        = '0;
    res.item_kind = mrrc_pkg::KIND_END;
    if (accept) begin
      case (in_data.req_type)
        mrrc_pkg::REQ_ARM: begin
          phase_nxt  = PH_ADDR;
          crc_nxt    = mrrc_pkg::CRC_INIT;
          seen_nxt   = '0;
          count_nxt  = '0;
          func_nxt   = '0;
          exc_nxt    = '0;
          crc_lo_nxt = '0;
        end
        mrrc_pkg::REQ_TIMEOUT: begin
          if (phase_r != PH_IDLE) begin
            res_valid  = 1'b1;
            res.status = mrrc_pkg::ST_TIMEOUT;
            phase_nxt  = PH_IDLE;
          end
        end
        mrrc_pkg::REQ_BYTE: begin
          case (phase_r)
            PH_ADDR: begin
              crc_nxt   = crc_byte;
              seen_nxt  = CNT_W'(1);
              phase_nxt = (b == addr_r) ? PH_B1_OK : PH_B1_BAD;
            end
            PH_B1_OK, PH_B1_BAD: begin
              crc_nxt   = crc_byte;
              seen_nxt  = CNT_W'(2);
              func_nxt  = b;
              phase_nxt = (phase_r == PH_B1_OK) ? PH_B2_OK : PH_B2_BAD;
            end
            PH_B2_OK, PH_B2_BAD: begin
              crc_nxt  = crc_byte;
              seen_nxt = CNT_W'(mrrc_pkg::HDR_BYTES);
              if (phase_r == PH_B2_BAD) begin
                res_valid  = 1'b1;
                res.status = mrrc_pkg::ST_BAD_ADDR;
                phase_nxt  = PH_IDLE;
              end else if ((func_r & mrrc_pkg::FUNC_EXC_BIT) != 8'h00) begin
                exc_nxt   = b;
                phase_nxt = PH_EXC_LO;
              end else if (func_r != mrrc_pkg::FUNC_READ_INP &&
                           func_r != mrrc_pkg::FUNC_READ_HLD) begin
                res_valid  = 1'b1;
                res.status = mrrc_pkg::ST_BAD_FUNC;
                phase_nxt  = PH_IDLE;
              end else if (b == 8'h00 || b > 8'(MAX_CNT)) begin
                res_valid  = 1'b1;
                res.status = mrrc_pkg::ST_BAD_LEN;
                phase_nxt  = PH_IDLE;
              end else begin
                count_nxt = CNT_W'(b);
                phase_nxt = PH_DATA;
              end
            end
            PH_EXC_LO, PH_CRC_LO: begin
              crc_lo_nxt = b;
              seen_nxt   = seen_r + CNT_W'(1);
              phase_nxt  = (phase_r == PH_EXC_LO) ? PH_EXC_HI : PH_CRC_HI;
            end
            PH_EXC_HI: begin
              res_valid = 1'b1;
              phase_nxt = PH_IDLE;
              if (rx_crc != crc_r) begin
                res.status = mrrc_pkg::ST_BAD_CRC;
              end else begin
                res.status         = mrrc_pkg::ST_EXCEPTION;
                res.exception_code = exc_r;
              end
            end
            PH_CRC_HI: begin
              res_valid          = 1'b1;
              phase_nxt          = PH_IDLE;
              res.status         = (rx_crc == crc_r) ? mrrc_pkg::ST_OK : mrrc_pkg::ST_BAD_CRC;
              res.payload_length = 7'(count_r);
            end
            PH_DATA: begin
              res_valid        = 1'b1;
              crc_nxt          = crc_byte;
              res.item_kind    = mrrc_pkg::KIND_PAYLOAD;
              res.payload_byte = b;
              res.byte_index   = 7'(seen_r - CNT_W'(mrrc_pkg::HDR_BYTES));
              seen_nxt         = seen_r + CNT_W'(1);
              if ({1'b0, seen_nxt} >= data_end) begin
                phase_nxt = PH_CRC_LO;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept && res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      crc_r       <= mrrc_pkg::CRC_INIT;
      seen_r      <= '0;
      count_r     <= '0;
      func_r      <= '0;
      exc_r       <= '0;
      crc_lo_r    <= '0;
      addr_r      <= mrrc_pkg::ADDR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      crc_r       <= crc_nxt;
      seen_r      <= seen_nxt;
      count_r     <= count_nxt;
      func_r      <= func_nxt;
      exc_r       <= exc_nxt;
      crc_lo_r    <= crc_lo_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        addr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_arm_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.req_type == mrrc_pkg::REQ_ARM |=> phase_r == PH_ADDR)
    else $error("arm did not restart frame check");

  a_end_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.item_kind == mrrc_pkg::KIND_END |-> phase_r == PH_IDLE)
    else $error("end transaction pending while frame still active");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> count_r != '0 && {1'b0, seen_r} < data_end)
    else $error("payload phase outside declared byte count");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(phase_r) && $stable(crc_r))
    else $error("state advanced while result stalled");

endmodule

// ===== tb/tb_checker.sv =====
// Response checker for the Modbus read-response block: watches the input, result
// and address channels, predicts each result and compares it field by field.
// Depends on mrrc_pkg for transaction structs and codes; holds mrrc_tb_pkg.
package mrrc_tb_pkg;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = (r[0] ^ d[k]) ? ((r >> 1) ^ mrrc_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

module tb_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 96
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mrrc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mrrc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mrrc_pkg::*;
  import mrrc_tb_pkg::*;

  typedef enum logic [3:0] {
    P_IDLE, P_ADDR, P_FUNC_OK, P_FUNC_BAD, P_CNT_OK, P_CNT_BAD,
    P_EXC_LO, P_EXC_HI, P_DATA, P_CRC_LO, P_CRC_HI
  } rx_phase_e;

  rx_phase_e   ph;
  logic [15:0] crc_acc;
  logic [6:0]  nbytes;
  logic [6:0]  nbytes_decl;
  logic [7:0]  func_b;
  logic [7:0]  exc_b;
  logic [7:0]  crc_lo_b;
  logic [7:0]  addr_cfg;
  out_item_t   resp_q[$];

  task automatic push_end(input logic [2:0] st, input logic [7:0] ec, input logic [6:0] len);
    out_item_t r;
    r = '0;
    r.item_kind = KIND_END;
    r.status = st;
    r.exception_code = ec;
    r.payload_length = len;
    resp_q.push_back(r);
    ph = P_IDLE;
  endtask

  task automatic track_rx(input in_item_t it);
    out_item_t  r;
    logic [7:0] b;
    b = it.rx_byte;
    if (it.req_type == REQ_ARM) begin
      ph = P_ADDR;
      crc_acc = CRC_INIT;
      nbytes = '0;
      nbytes_decl = '0;
      func_b = '0;
      exc_b = '0;
      crc_lo_b = '0;
    end else if (it.req_type == REQ_TIMEOUT) begin
      if (ph != P_IDLE) push_end(ST_TIMEOUT, 8'h00, 7'd0);
    end else if (it.req_type == REQ_BYTE && ph != P_IDLE) begin
      case (ph)
        P_ADDR: begin
          crc_acc = crc16_next(crc_acc, b);
          nbytes = 7'd1;
          ph = (b == addr_cfg) ? P_FUNC_OK : P_FUNC_BAD;
        end
        P_FUNC_OK, P_FUNC_BAD: begin
          crc_acc = crc16_next(crc_acc, b);
          nbytes = 7'd2;
          func_b = b;
          ph = (ph == P_FUNC_OK) ? P_CNT_OK : P_CNT_BAD;
        end
        P_CNT_OK, P_CNT_BAD: begin
          crc_acc = crc16_next(crc_acc, b);
          nbytes = 7'd3;
          if (ph == P_CNT_BAD) begin
            push_end(ST_BAD_ADDR, 8'h00, 7'd0);
          end else if ((func_b & FUNC_EXC_BIT) != 8'h00) begin
            exc_b = b;
            ph = P_EXC_LO;
          end else if (func_b != FUNC_READ_INP && func_b != FUNC_READ_HLD) begin
            push_end(ST_BAD_FUNC, 8'h00, 7'd0);
          end else if (b == 8'h00 || int'(b) + OVERHEAD > MAX_FRAME_BYTES) begin
            push_end(ST_BAD_LEN, 8'h00, 7'd0);
          end else begin
            nbytes_decl = b[6:0];
            ph = P_DATA;
          end
        end
        P_EXC_LO, P_CRC_LO: begin
          crc_lo_b = b;
          nbytes = nbytes + 7'd1;
          ph = (ph == P_EXC_LO) ? P_EXC_HI : P_CRC_HI;
        end
        P_EXC_HI: begin
          if ({b, crc_lo_b} != crc_acc) push_end(ST_BAD_CRC, 8'h00, 7'd0);
          else push_end(ST_EXCEPTION, exc_b, 7'd0);
        end
        P_CRC_HI: begin
          push_end(({b, crc_lo_b} == crc_acc) ? ST_OK : ST_BAD_CRC, 8'h00, nbytes_decl);
        end
        P_DATA: begin
          crc_acc = crc16_next(crc_acc, b);
          r = '0;
          r.item_kind = KIND_PAYLOAD;
          r.payload_byte = b;
          r.byte_index = 7'(int'(nbytes) - HDR_BYTES);
          resp_q.push_back(r);
          nbytes = nbytes + 7'd1;
          if (int'(nbytes) >= HDR_BYTES + int'(nbytes_decl)) ph = P_CRC_LO;
        end
        default: ph = P_IDLE;
      endcase
    end
  endtask

  task automatic cmp_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      ph = P_IDLE;
      crc_acc = CRC_INIT;
      nbytes = '0;
      nbytes_decl = '0;
      func_b = '0;
      exc_b = '0;
      crc_lo_b = '0;
      addr_cfg = ADDR_RESET;
      resp_q.delete();
      errors = 0;
    end else begin
      if (in_valid && in_ready) track_rx(in_data);
      if (cfg_valid && cfg_ready) addr_cfg = cfg_data;
      if (out_valid && out_ready) begin
        if (resp_q.size() == 0) begin
          errors++;
          $display("%0t: result expected none actual %h", $time, out_data);
        end else begin
          want = resp_q.pop_front();
          cmp_field("item_kind", 8'(want.item_kind), 8'(out_data.item_kind));
          cmp_field("payload_byte", want.payload_byte, out_data.payload_byte);
          cmp_field("byte_index", 8'(want.byte_index), 8'(out_data.byte_index));
          cmp_field("status", 8'(want.status), 8'(out_data.status));
          cmp_field("exception_code", want.exception_code, out_data.exception_code);
          cmp_field("payload_length", 8'(want.payload_length), 8'(out_data.payload_length));
        end
      end
    end
    pending = resp_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for modbus_read_response_checker_core: clock, reset, frame stimulus
// and the address register writes, with tb_checker doing prediction and compare.
// Depends on mrrc_pkg, mrrc_tb_pkg and tb_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mrrc_pkg::*;
  import mrrc_tb_pkg::*;

  localparam int MAX_LEN = MAX_FRAME_BYTES_DEF - OVERHEAD;

  localparam int K_GOOD        = 0;
  localparam int K_BAD_CRC     = 45;
  localparam int K_EXC         = 55;
  localparam int K_EXC_BAD_CRC = 63;
  localparam int K_BAD_ADDR    = 66;
  localparam int K_BAD_FUNC    = 72;
  localparam int K_BAD_LEN     = 78;
  localparam int K_CUT_TIMEOUT = 84;
  localparam int K_CUT_REARM   = 92;
  localparam int K_NOISE       = 96;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  in_item_t   in_data = '0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data = ADDR_RESET;
  logic       in_ready;
  logic       out_valid;
  logic       cfg_ready;
  out_item_t  out_data;
  int         errors;
  int         pending;

  bit         quiet = 1'b0;
  logic [7:0] addr_now = ADDR_RESET;
  int         sent = 0;
  logic [7:0] frame_q[$];

  always #5 clk = ~clk;

  modbus_read_response_checker_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES_DEF)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  tb_checker #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES_DEF)
  ) i_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 6);
    end
  end

  task automatic send_item(input logic [1:0] r, input logic [7:0] b);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 6) ? 1 : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {r, b};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_frame_q(input int cut);
    for (int i = 0; i < cut; i++) send_item(REQ_BYTE, frame_q[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_addr(input logic [7:0] a);
    // close any open frame so the write lands while idle
    send_item(REQ_TIMEOUT, 8'h00);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    addr_now = a;
    repeat (2) @(posedge clk);
  endtask

  task automatic seal_crc(input bit bad);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_q[i]) c = crc16_next(c, frame_q[i]);
    if (bad) c ^= 16'(1) << $urandom_range(0, 15);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  task automatic rand_frame(input int kind_sel, input int n_sel);
    int         kind;
    int         n;
    int         cut;
    logic [7:0] fn;
    logic [7:0] cnt;
    kind = (kind_sel < 0) ? $urandom_range(0, 99) : kind_sel;
    if (kind >= K_NOISE) begin
      repeat ($urandom_range(1, 4)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
      return;
    end
    if (n_sel > 0) n = n_sel;
    else if ($urandom_range(0, 19) == 0) n = $urandom_range(9, MAX_LEN);
    else n = $urandom_range(1, 8);
    fn = ($urandom_range(0, 1) != 0) ? FUNC_READ_HLD : FUNC_READ_INP;
    cnt = 8'(n);
    if (kind >= K_BAD_FUNC && kind < K_BAD_LEN) begin
      do fn = 8'($urandom_range(0, 127)); while (fn == FUNC_READ_HLD || fn == FUNC_READ_INP);
    end
    if (kind >= K_BAD_LEN && kind < K_CUT_TIMEOUT) begin
      case ($urandom_range(0, 3))
        0: cnt = 8'h00;
        1: cnt = 8'(MAX_LEN + 1);
        default: cnt = 8'($urandom_range(MAX_LEN + 2, 255));
      endcase
    end
    frame_q.delete();
    if (kind >= K_BAD_ADDR && kind < K_BAD_FUNC) begin
      frame_q.push_back(addr_now ^ 8'($urandom_range(1, 255)));
    end else begin
      frame_q.push_back(addr_now);
    end
    if (kind >= K_EXC && kind < K_BAD_ADDR) begin
      frame_q.push_back(FUNC_EXC_BIT | 8'($urandom));
      frame_q.push_back(8'($urandom));
    end else begin
      frame_q.push_back(fn);
      frame_q.push_back(cnt);
      repeat (n) frame_q.push_back(8'($urandom));
    end
    seal_crc((kind >= K_BAD_CRC && kind < K_EXC) ||
             (kind >= K_EXC_BAD_CRC && kind < K_BAD_ADDR));
    send_item(REQ_ARM, 8'($urandom));
    cut = (kind >= K_CUT_TIMEOUT) ? $urandom_range(0, frame_q.size() - 1) : frame_q.size();
    send_frame_q(cut);
    if (kind >= K_CUT_TIMEOUT && kind < K_CUT_REARM) send_item(REQ_TIMEOUT, 8'($urandom));
  endtask

  initial begin
    int         start;
    logic [7:0] a;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // not armed: all ignored
    send_item(REQ_BYTE, 8'hFF);
    send_item(REQ_TIMEOUT, 8'h00);
    send_item(REQ_UNUSED, 8'h55);

    frame_q = {ADDR_RESET, FUNC_READ_INP, 8'h01, 8'hFF};
    seal_crc(1'b0);
    send_item(REQ_ARM, 8'h00);
    send_item(REQ_UNUSED, 8'hAA);
    send_frame_q(frame_q.size());

    // re-arm, then an exception frame
    frame_q = {ADDR_RESET, FUNC_EXC_BIT | FUNC_READ_HLD, 8'hFF};
    seal_crc(1'b0);
    send_item(REQ_ARM, 8'hFF);
    send_item(REQ_ARM, 8'h00);
    send_frame_q(frame_q.size());

    frame_q = {8'hF7, FUNC_READ_HLD, 8'h00};
    send_item(REQ_ARM, 8'h00);
    send_frame_q(frame_q.size());

    send_item(REQ_ARM, 8'h00);
    send_item(REQ_BYTE, ADDR_RESET);
    send_item(REQ_TIMEOUT, 8'hFF);

    for (int p = 0; p < 5; p++) begin
      if (p == 0) a = 8'd247;
      else if (p == 2) a = ADDR_RESET;
      else a = 8'($urandom_range(2, 246));
      set_addr(a);
      quiet = (p == 2);
      if (p == 0) rand_frame(K_GOOD, MAX_LEN);
      if (p == 4) rand_frame(K_BAD_CRC, MAX_LEN);
      start = sent;
      while (sent - start < 36) rand_frame(-1, 0);
      quiet = 1'b0;
    end

    send_item(REQ_TIMEOUT, 8'h00);
    drain();
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
src/mrrc_pkg.sv
src/modbus_read_response_checker_core.sv
tb/tb_checker.sv
tb/tb_top.sv
